// ----- src/imh_pkg.sv -----
// Shared types for the indexed min-heap unit: commands, status codes,
// sequencer states and the request and result transfer structures.
// Depends on nothing.
`default_nettype none
package imh_pkg;

    typedef enum logic [1:0] {
        CMD_INSERT = 2'd0,
        CMD_DEL_MIN = 2'd1,
        CMD_DEL_HANDLE = 2'd2,
        CMD_CHANGE = 2'd3
    } cmd_t;

    typedef enum logic [2:0] {
        ST_OK = 3'd0,
        ST_FULL = 3'd1,
        ST_EMPTY = 3'd2,
        ST_DEAD = 3'd3,
        ST_EXHAUSTED = 3'd4
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_HS_CHK,
        S_LAST_WAIT,
        S_UP_RD,
        S_UP_CMP,
        S_DN_RD,
        S_DN_CMP,
        S_FIN
    } state_t;

    typedef struct packed {
        cmd_t command;
        logic [10:0] handle;
        logic signed [31:0] value;
    } request_t;

    typedef struct packed {
        status_t status;
        logic [10:0] new_handle;
        logic min_valid;
        logic signed [31:0] min_value;
        logic [10:0] heap_size;
    } result_t;

endpackage
`default_nettype wire

// ----- src/imh_ram.sv -----
// Simple synchronous RAM: one write port and one read port with registered
// read data. Depends on nothing.
`default_nettype none
module imh_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 4
) (
    input wire logic clk,
    input wire logic we,
    input wire logic [$clog2(DEPTH)-1:0] waddr,
    input wire logic [WIDTH-1:0] wdata,
    input wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0] rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

// ----- src/indexed_min_heap_unit.sv -----
// Indexed binary min-heap: top level with command sequencer and heap memories.
// An error goes from the accepted transfer straight to the finish state, or
// through the handle check first when the handle is found dead in the handle
// memory; a successful command walks the heap level by level, each level
// costing one read and one compare-and-write of the slot memory. One command
// is in flight at a time. The result strobe cannot be stalled. Reset clears
// the counts and control state only; the memories need no clearing.
`default_nettype none
module indexed_min_heap_unit #(
    parameter int HEAP_CAPACITY = 1024,
    parameter int HANDLE_SPACE = 1024
) (
    input wire logic clk,
    input wire logic rst_n,
    input wire logic start,
    input wire imh_pkg::request_t request,
    output logic busy,
    output logic done,
    output imh_pkg::result_t result
);
    import imh_pkg::*;

    localparam int AW = $clog2(HEAP_CAPACITY);
    localparam int HW = $clog2(HANDLE_SPACE);
    localparam int SW = $clog2(HEAP_CAPACITY + 1);
    localparam int IW = $clog2(HANDLE_SPACE + 1);
    localparam int CW = AW + 2;
    localparam int SLW = 32 + HW;
    localparam int HSW = 1 + AW;

    // Each slot holds its key and its handle index; each handle entry holds a
    // live flag and its slot. A handle entry is only trusted below the issued
    // count, so handle entries never written are never consulted.
    state_t state_reg, state_next;
    cmd_t cmd_reg, cmd_next;
    logic signed [31:0] val_reg, val_next;
    logic [HW-1:0] hidx_reg, hidx_next;
    logic [AW-1:0] pos_reg, pos_next;
    logic signed [31:0] mk_reg, mk_next;
    logic [HW-1:0] mh_reg, mh_next;
    logic moved_reg, moved_next;
    logic [SW-1:0] size_reg, size_next;
    logic [IW-1:0] issued_reg, issued_next;
    logic signed [31:0] root_key_reg;
    logic [HW-1:0] root_h_reg;
    status_t status_reg, status_next;
    logic done_reg, done_next;
    result_t result_reg, result_next;

    logic s_we;
    logic [AW-1:0] s_waddr;
    logic [SLW-1:0] s_wdata;
    logic [AW-1:0] sa_raddr, sb_raddr;
    logic [SLW-1:0] sa_rdata, sb_rdata;
    logic h_we;
    logic [HW-1:0] h_waddr, h_raddr;
    logic [HSW-1:0] h_wdata, h_rdata;

    // The slot memory is kept twice so that both children can be read at once.
    imh_ram #(.WIDTH(SLW), .DEPTH(HEAP_CAPACITY)) u_slot_a (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(sa_raddr), .rdata(sa_rdata)
    );
    imh_ram #(.WIDTH(SLW), .DEPTH(HEAP_CAPACITY)) u_slot_b (
        .clk(clk), .we(s_we), .waddr(s_waddr), .wdata(s_wdata),
        .raddr(sb_raddr), .rdata(sb_rdata)
    );
    imh_ram #(.WIDTH(HSW), .DEPTH(HANDLE_SPACE)) u_handle_slot (
        .clk(clk), .we(h_we), .waddr(h_waddr), .wdata(h_wdata),
        .raddr(h_raddr), .rdata(h_rdata)
    );

    logic [CW-1:0] left_idx, right_idx, size_ext;
    logic [AW-1:0] parent_idx, last_idx;
    logic signed [31:0] a_key, b_key;
    logic [HW-1:0] a_h, b_h;
    logic [31:0] req_h32;

    assign left_idx = {1'b0, pos_reg, 1'b1};
    assign right_idx = left_idx + CW'(1);
    assign size_ext = CW'(size_reg);
    assign parent_idx = (pos_reg - AW'(1)) >> 1;
    assign last_idx = AW'(size_reg - SW'(1));
    assign a_key = $signed(sa_rdata[SLW-1:HW]);
    assign a_h = sa_rdata[HW-1:0];
    assign b_key = $signed(sb_rdata[SLW-1:HW]);
    assign b_h = sb_rdata[HW-1:0];
    assign req_h32 = 32'(request.handle);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            size_reg <= '0;
            issued_reg <= '0;
            done_reg <= 1'b0;
        end
        else
        begin
            state_reg <= state_next;
            size_reg <= size_next;
            issued_reg <= issued_next;
            done_reg <= done_next;
        end
    end

    always_ff @(posedge clk)
    begin
        cmd_reg <= cmd_next;
        val_reg <= val_next;
        hidx_reg <= hidx_next;
        pos_reg <= pos_next;
        mk_reg <= mk_next;
        mh_reg <= mh_next;
        moved_reg <= moved_next;
        status_reg <= status_next;
        result_reg <= result_next;
        // The root is mirrored so the minimum and its handle need no read.
        if (s_we && s_waddr == '0)
        begin
            root_key_reg <= $signed(s_wdata[SLW-1:HW]);
            root_h_reg <= s_wdata[HW-1:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        cmd_next = cmd_reg;
        val_next = val_reg;
        hidx_next = hidx_reg;
        pos_next = pos_reg;
        mk_next = mk_reg;
        mh_next = mh_reg;
        moved_next = moved_reg;
        size_next = size_reg;
        issued_next = issued_reg;
        status_next = status_reg;
        done_next = 1'b0;
        result_next = result_reg;
        s_we = 1'b0;
        s_waddr = pos_reg;
        s_wdata = {mk_reg, mh_reg};
        sa_raddr = last_idx;
        sb_raddr = right_idx[AW-1:0];
        h_we = 1'b0;
        h_waddr = mh_reg;
        h_wdata = {1'b1, pos_reg};
        h_raddr = HW'(req_h32 - 32'd1);

        case (state_reg)
            S_IDLE:
            begin
                if (start)
                begin
                    cmd_next = request.command;
                    val_next = request.value;
                    status_next = ST_OK;
                    moved_next = 1'b0;
                    state_next = S_FIN;
                    case (request.command)
                        CMD_INSERT:
                        begin
                            if (32'(size_reg) >= HEAP_CAPACITY)
                            begin
                                status_next = ST_FULL;
                            end
                            else if (32'(issued_reg) >= HANDLE_SPACE)
                            begin
                                status_next = ST_EXHAUSTED;
                            end
                            else
                            begin
                                pos_next = AW'(size_reg);
                                mk_next = request.value;
                                mh_next = HW'(issued_reg);
                                size_next = size_reg + SW'(1);
                                issued_next = issued_reg + IW'(1);
                                state_next = S_UP_RD;
                            end
                        end
                        CMD_DEL_MIN:
                        begin
                            if (size_reg == '0)
                            begin
                                status_next = ST_EMPTY;
                            end
                            else
                            begin
                                // Retire the root's handle and pull in the last slot.
                                h_we = 1'b1;
                                h_waddr = root_h_reg;
                                h_wdata = '0;
                                size_next = size_reg - SW'(1);
                                pos_next = '0;
                                sa_raddr = last_idx;
                                if (last_idx != '0)
                                begin
                                    state_next = S_LAST_WAIT;
                                end
                            end
                        end
                        default:
                        begin
                            if (req_h32 == 32'd0 || req_h32 > HANDLE_SPACE
                                || req_h32 > 32'(issued_reg))
                            begin
                                status_next = ST_DEAD;
                            end
                            else
                            begin
                                hidx_next = HW'(req_h32 - 32'd1);
                                state_next = S_HS_CHK;
                            end
                        end
                    endcase
                end
            end
            S_HS_CHK:
            begin
                if (!h_rdata[AW])
                begin
                    status_next = ST_DEAD;
                    state_next = S_FIN;
                end
                else if (cmd_reg == CMD_CHANGE)
                begin
                    pos_next = h_rdata[AW-1:0];
                    mk_next = val_reg;
                    mh_next = hidx_reg;
                    state_next = S_UP_RD;
                end
                else
                begin
                    h_we = 1'b1;
                    h_waddr = hidx_reg;
                    h_wdata = '0;
                    size_next = size_reg - SW'(1);
                    pos_next = h_rdata[AW-1:0];
                    sa_raddr = last_idx;
                    // Removing the last slot needs no reordering.
                    if (h_rdata[AW-1:0] == last_idx)
                    begin
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_LAST_WAIT;
                    end
                end
            end
            S_LAST_WAIT:
            begin
                mk_next = a_key;
                mh_next = a_h;
                state_next = S_UP_RD;
            end
            S_UP_RD:
            begin
                if (pos_reg == '0)
                begin
                    if (moved_reg)
                    begin
                        s_we = 1'b1;
                        h_we = 1'b1;
                        state_next = S_FIN;
                    end
                    else
                    begin
                        state_next = S_DN_RD;
                    end
                end
                else
                begin
                    sa_raddr = parent_idx;
                    state_next = S_UP_CMP;
                end
            end
            S_UP_CMP:
            begin
                if (mk_reg < a_key)
                begin
                    // Parent moves down into the hole.
                    s_we = 1'b1;
                    s_wdata = sa_rdata;
                    h_we = 1'b1;
                    h_waddr = a_h;
                    pos_next = parent_idx;
                    moved_next = 1'b1;
                    state_next = S_UP_RD;
                end
                else if (moved_reg)
                begin
                    s_we = 1'b1;
                    h_we = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    state_next = S_DN_RD;
                end
            end
            S_DN_RD:
            begin
                if (left_idx >= size_ext)
                begin
                    s_we = 1'b1;
                    h_we = 1'b1;
                    state_next = S_FIN;
                end
                else
                begin
                    sa_raddr = left_idx[AW-1:0];
                    sb_raddr = right_idx[AW-1:0];
                    state_next = S_DN_CMP;
                end
            end
            S_DN_CMP:
            begin
                // Left wins ties; right is taken only when strictly smaller.
                if (right_idx < size_ext && b_key < a_key && b_key < mk_reg)
                begin
                    s_we = 1'b1;
                    s_wdata = sb_rdata;
                    h_we = 1'b1;
                    h_waddr = b_h;
                    pos_next = right_idx[AW-1:0];
                    state_next = S_DN_RD;
                end
                else if (a_key < mk_reg)
                begin
                    s_we = 1'b1;
                    s_wdata = sa_rdata;
                    h_we = 1'b1;
                    h_waddr = a_h;
                    pos_next = left_idx[AW-1:0];
                    state_next = S_DN_RD;
                end
                else
                begin
                    s_we = 1'b1;
                    h_we = 1'b1;
                    state_next = S_FIN;
                end
            end
            S_FIN:
            begin
                done_next = 1'b1;
                result_next.status = status_reg;
                result_next.new_handle = (cmd_reg == CMD_INSERT && status_reg == ST_OK)
                    ? 11'(issued_reg) : 11'd0;
                result_next.min_valid = (size_reg != '0);
                result_next.min_value = (size_reg != '0) ? root_key_reg : 32'sd0;
                result_next.heap_size = 11'(size_reg);
                state_next = S_IDLE;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    assign busy = (state_reg != S_IDLE);
    assign done = done_reg;
    assign result = result_reg;

    // A result transfer only appears once the sequencer has gone back to idle.
    assert property (@(posedge clk) disable iff (!rst_n) done |-> !busy)
        else $error("result strobe while busy");
    // The reported minimum is valid exactly when the heap is not empty.
    assert property (@(posedge clk) disable iff (!rst_n)
        done |-> (result.min_valid == (result.heap_size != 11'd0)))
        else $error("min_valid disagrees with heap_size");
    // An accepted command always occupies the sequencer in the next cycle.
    assert property (@(posedge clk) disable iff (!rst_n) (start && !busy) |=> busy)
        else $error("command accepted without sequencer activity");
    // The key count never exceeds the capacity.
    assert property (@(posedge clk) disable iff (!rst_n) 32'(size_reg) <= HEAP_CAPACITY)
        else $error("heap size beyond capacity");
endmodule
`default_nettype wire
